/* hw/rtl/srp_pkg.sv */
// Shared types and constants of the stereo reverse playback core.
// Used by the channel interfaces and by the top-level core; depends on nothing.
package srp_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAME_BITS = 2 * SAMPLE_BITS;
    localparam int LENGTH_BITS = 19;
    localparam int MIN_LENGTH = 2;
    localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 19'd192000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          play_active;
        logic                          forward_dir;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_word_t;

endpackage

/* hw/rtl/srp_channels.sv */
// Valid/ready channel interfaces for input and output words.
// Depends on srp_pkg for the payload types.
interface srp_in_if;
    logic             valid;
    logic             ready;
    srp_pkg::in_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface srp_out_if;
    logic               valid;
    logic               ready;
    srp_pkg::out_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/stereo_reverse_playback_core.sv */
// Top level of the stereo reverse playback core: sequencer, work and play stores.
// Depends on srp_pkg, srp_channels, srp_ram and srp_mod.
//
//   Port       Kind        Word                     Handshake
//   capture    sink        in_word_t (two samples)  valid/ready
//   playback   source      out_word_t (two samples) valid/ready
//   cfg_*      write only  buffer_length (19 bits)  cfg_we
//
// A frame steps through idle, write, read and finish; passing through skips the play store read.
// Shrinking the length reduces the write and read indices in the remainder unit.
// The first active frame after reset or after a pass-through frame copies the work store into the play store.
// After reset a clearing pass over every address zeroes both stores; no frame is taken.
// The output register lets a new frame enter while the last result waits to be taken.
module stereo_reverse_playback_core #(
    parameter int MAX_FRAMES = 262144
) (
    input  logic                               clk,
    input  logic                               rst_n,
    srp_in_if.sink                             capture,
    srp_out_if.source                          playback,
    input  logic                               cfg_we,
    input  logic [srp_pkg::LENGTH_BITS-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_FRAMES);
    localparam int LEN_W = $clog2(MAX_FRAMES + 1);
    localparam int BL_W = srp_pkg::LENGTH_BITS;
    localparam int CW = (LEN_W > BL_W) ? LEN_W : BL_W;
    localparam int FW = srp_pkg::FRAME_BITS;
    localparam int SW = srp_pkg::SAMPLE_BITS;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_REDUCE_W = 3'd2;
    localparam logic [2:0] ST_REDUCE_R = 3'd3;
    localparam logic [2:0] ST_WRITE    = 3'd4;
    localparam logic [2:0] ST_COPY     = 3'd5;
    localparam logic [2:0] ST_READ     = 3'd6;
    localparam logic [2:0] ST_FINISH   = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [BL_W-1:0]          blen_reg, blen_next;
    logic [IDX_W-1:0]         clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]         wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]         refresh_reg, refresh_next;
    logic                     snap_reg, snap_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEN_W-1:0]         cp_issue_reg, cp_issue_next;
    logic                     cp_pend_reg, cp_pend_next;
    logic [IDX_W-1:0]         cp_addr_reg, cp_addr_next;
    logic                     out_valid_reg, out_valid_next;
    srp_pkg::out_word_t       out_reg, out_next;
    srp_pkg::in_word_t        item_reg, item_next;

    logic [CW-1:0]            blen_ext;
    logic [CW-1:0]            len_sat;
    logic [LEN_W-1:0]         len_now;
    logic                     w_ge_now;
    logic                     r_ge_now;
    logic                     r_ge_reg;
    logic [IDX_W-1:0]         w_step;
    logic [IDX_W-1:0]         r_step;

    logic                     work_we, work_re, play_we, play_re;
    logic [IDX_W-1:0]         work_waddr, work_raddr, play_waddr, play_raddr;
    logic [FW-1:0]            work_wdata, play_wdata, work_rdata, play_rdata;

    logic                     mod_start, mod_done;
    logic [IDX_W-1:0]         mod_dividend, mod_rem;
    logic [LEN_W-1:0]         mod_divisor;

    srp_ram #(.DEPTH(MAX_FRAMES), .WIDTH(FW)) u_work (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .re    (work_re),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    srp_ram #(.DEPTH(MAX_FRAMES), .WIDTH(FW)) u_play (
        .clk   (clk),
        .we    (play_we),
        .waddr (play_waddr),
        .wdata (play_wdata),
        .re    (play_re),
        .raddr (play_raddr),
        .rdata (play_rdata)
    );

    srp_mod #(.IDX_W(IDX_W), .LEN_W(LEN_W)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        blen_ext = CW'(blen_reg);
        if (blen_ext < CW'(srp_pkg::MIN_LENGTH))
        begin
            len_sat = CW'(srp_pkg::MIN_LENGTH);
        end
        else if (blen_ext > CW'(MAX_FRAMES))
        begin
            len_sat = CW'(MAX_FRAMES);
        end
        else
        begin
            len_sat = blen_ext;
        end
    end

    assign len_now = len_sat[LEN_W-1:0];
    assign w_ge_now = LEN_W'(wr_idx_reg) >= len_now;
    assign r_ge_now = LEN_W'(rd_idx_reg) >= len_now;
    assign r_ge_reg = LEN_W'(rd_idx_reg) >= len_reg;
    assign mod_divisor = (state_reg == ST_IDLE) ? len_now : len_reg;

    assign w_step = (LEN_W'(wr_idx_reg) + 1'b1 == len_reg) ? '0 : wr_idx_reg + 1'b1;

    always_comb
    begin
        if (item_reg.forward_dir)
        begin
            r_step = (LEN_W'(rd_idx_reg) + 1'b1 == len_reg) ? '0 : rd_idx_reg + 1'b1;
        end
        else if (rd_idx_reg == '0)
        begin
            r_step = IDX_W'(len_reg - 1'b1);
        end
        else
        begin
            r_step = rd_idx_reg - 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        blen_next = cfg_we ? cfg_wdata : blen_reg;
        clr_addr_next = clr_addr_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        refresh_next = refresh_reg;
        snap_next = snap_reg;
        len_next = len_reg;
        cp_issue_next = cp_issue_reg;
        cp_pend_next = cp_pend_reg;
        cp_addr_next = cp_addr_reg;
        out_valid_next = out_valid_reg && !playback.ready;
        out_next = out_reg;
        item_next = item_reg;
        work_we = 1'b0;
        work_waddr = wr_idx_reg;
        work_wdata = {item_reg.left_sample, item_reg.right_sample};
        work_re = 1'b0;
        work_raddr = cp_issue_reg[IDX_W-1:0];
        play_we = 1'b0;
        play_waddr = wr_idx_reg;
        play_wdata = {item_reg.left_sample, item_reg.right_sample};
        play_re = 1'b0;
        play_raddr = rd_idx_reg;
        mod_start = 1'b0;
        mod_dividend = wr_idx_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                work_we = 1'b1;
                work_waddr = clr_addr_reg;
                work_wdata = '0;
                play_we = 1'b1;
                play_waddr = clr_addr_reg;
                play_wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(MAX_FRAMES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (capture.valid)
                begin
                    item_next = capture.payload;
                    len_next = len_now;
                    if (w_ge_now)
                    begin
                        mod_start = 1'b1;
                        mod_dividend = wr_idx_reg;
                        state_next = ST_REDUCE_W;
                    end
                    else if (r_ge_now)
                    begin
                        mod_start = 1'b1;
                        mod_dividend = rd_idx_reg;
                        state_next = ST_REDUCE_R;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_REDUCE_W:
            begin
                if (mod_done)
                begin
                    wr_idx_next = mod_rem;
                    if (r_ge_reg)
                    begin
                        mod_start = 1'b1;
                        mod_dividend = rd_idx_reg;
                        state_next = ST_REDUCE_R;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_REDUCE_R:
            begin
                if (mod_done)
                begin
                    rd_idx_next = mod_rem;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                work_we = 1'b1;
                wr_idx_next = w_step;
                if (item_reg.play_active)
                begin
                    rd_idx_next = r_step;
                    if (snap_reg)
                    begin
                        snap_next = 1'b0;
                        refresh_next = '0;
                        cp_issue_next = '0;
                        cp_pend_next = 1'b0;
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        if (LEN_W'(refresh_reg) < (len_reg >> 1))
                        begin
                            play_we = 1'b1;
                            refresh_next = refresh_reg + 1'b1;
                        end
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    rd_idx_next = wr_idx_reg;
                    snap_next = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_COPY:
            begin
                cp_pend_next = cp_issue_reg != len_reg;
                cp_addr_next = cp_issue_reg[IDX_W-1:0];
                if (cp_issue_reg != len_reg)
                begin
                    work_re = 1'b1;
                    cp_issue_next = cp_issue_reg + 1'b1;
                end
                if (cp_pend_reg)
                begin
                    play_we = 1'b1;
                    play_waddr = cp_addr_reg;
                    play_wdata = work_rdata;
                end
                else if (cp_issue_reg == len_reg)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                play_re = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || playback.ready)
                begin
                    out_valid_next = 1'b1;
                    if (item_reg.play_active)
                    begin
                        out_next.left_out = play_rdata[FW-1:SW];
                        out_next.right_out = play_rdata[SW-1:0];
                    end
                    else
                    begin
                        out_next.left_out = item_reg.left_sample;
                        out_next.right_out = item_reg.right_sample;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            blen_reg <= srp_pkg::LENGTH_RESET;
            clr_addr_reg <= '0;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            refresh_reg <= '0;
            snap_reg <= 1'b1;
            cp_issue_reg <= '0;
            cp_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            blen_reg <= blen_next;
            clr_addr_reg <= clr_addr_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            refresh_reg <= refresh_next;
            snap_reg <= snap_next;
            cp_issue_reg <= cp_issue_next;
            cp_pend_reg <= cp_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        cp_addr_reg <= cp_addr_next;
        out_reg <= out_next;
        item_reg <= item_next;
    end

    assign capture.ready = (state_reg == ST_IDLE);
    assign playback.valid = out_valid_reg;
    assign playback.payload = out_reg;

`ifndef SYNTHESIS
    a_index_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |->
            (LEN_W'(wr_idx_reg) < len_reg) && (LEN_W'(rd_idx_reg) < len_reg))
        else $error("store index not reduced below the length");

    a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && play_we) |-> (LEN_W'(play_waddr) < len_reg))
        else $error("snapshot copy beyond the store length");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output word loaded outside the finish step");
`endif

endmodule

/* hw/rtl/srp_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Stand-alone; used for the work store and the play store.
module srp_ram #(
    parameter int DEPTH = 262144,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/srp_mod.sv */
// Bit-serial remainder unit: reduces an index modulo the store length.
// Takes one dividend bit per cycle; depends on nothing else.
module srp_mod #(
    parameter int IDX_W = 18,
    parameter int LEN_W = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [LEN_W-1:0] divisor,
    output logic             done,
    output logic [IDX_W-1:0] remainder
);

    localparam int CNT_W = $clog2(IDX_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] div_reg, div_next;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;

    assign trial = {rem_reg, shift_reg[IDX_W-1]};
    assign diff = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        shift_next = shift_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(IDX_W);
            shift_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[LEN_W-1:0];
            end
            else
            begin
                rem_next = trial[LEN_W-1:0];
            end
            shift_next = {shift_reg[IDX_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign remainder = rem_reg[IDX_W-1:0];

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("remainder done while still busy");
`endif

endmodule
